// File: src/circular_byte_deque_macros.svh
// Assertion macros for the deque.
`ifndef CIRCULAR_BYTE_DEQUE_MACROS_SVH
`define CIRCULAR_BYTE_DEQUE_MACROS_SVH

`ifndef SYNTH

`define CDQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`define CDQ_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CDQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)

`define CDQ_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// File: src/cdq_pkg.sv
`default_nettype none

package cdq_pkg;

    localparam int DEPTH  = 16;
    localparam int NCELL  = DEPTH - 1;
    localparam int CNT_W  = $clog2(DEPTH);
    localparam int ACT_W  = 3;
    localparam int DATA_W = 8;
    localparam int STAT_W = 2;
    localparam int FILL_W = 4;

    localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH_REAR  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_POP_REAR   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_PEEK_FRONT = 3'd4;
    localparam logic [ACT_W-1:0] ACT_PEEK_REAR  = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic load;
        logic take_left;
        logic take_right;
    } cdq_cell_ctrl_t;

endpackage

`default_nettype wire

// File: src/cdq_cell.sv
`default_nettype none

module cdq_cell
    import cdq_pkg::*;
(
    input  wire logic           clk,
    input  wire cdq_cell_ctrl_t ctrl,
    input  wire logic [DATA_W-1:0] left_in,
    input  wire logic [DATA_W-1:0] right_in,
    input  wire logic [DATA_W-1:0] item,
    output logic [DATA_W-1:0]      data
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.load)
        begin
            data_next = item;
        end
        else if (ctrl.take_left)
        begin
            data_next = left_in;
        end
        else if (ctrl.take_right)
        begin
            data_next = right_in;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// File: src/circular_byte_deque.sv
// channel  | handshake                 | fields
// ---------+---------------------------+----------------------
// command  | start, busy (accept: start & !busy) | action, item
// result   | done (one-cycle strobe)   | value, status, fill
//
// One beat per cycle: a command accepted at one edge updates the cell row
// at that edge and its result strobes on done for the next cycle.
// busy stays low; a command may follow in every cycle.
// The front item sits in cell 0; pushes and pops at the front shift the row.
// Reset clears the item count; cell contents are undefined until written.
// The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none

`include "circular_byte_deque_macros.svh"

module circular_byte_deque
    import cdq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [ACT_W-1:0]  action,
    input  wire logic [DATA_W-1:0] item,
    output logic                   done,
    output logic [DATA_W-1:0]      value,
    output logic [STAT_W-1:0]      status,
    output logic [FILL_W-1:0]      fill
);

    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              done_reg;
    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;
    logic [STAT_W-1:0] status_reg;
    logic [STAT_W-1:0] status_next;
    logic [FILL_W-1:0] fill_reg;

    logic              accept;
    logic              empty;
    logic              full;
    logic              do_push_front;
    logic              do_push_rear;
    logic              do_pop_front;
    logic [DATA_W-1:0] rear_data;

    logic [DATA_W-1:0]  cell_data [NCELL];
    cdq_cell_ctrl_t     cell_ctrl [NCELL];

    assign accept = start && !busy;
    assign busy   = 1'b0;
    assign empty  = (cnt_reg == '0);
    assign full   = (cnt_reg == CNT_W'(NCELL));

    always_comb
    begin
        rear_data = '0;
        for (int i = 0; i < NCELL; i++)
        begin
            if (cnt_reg == CNT_W'(i + 1))
            begin
                rear_data = cell_data[i];
            end
        end
    end

    always_comb
    begin
        cnt_next      = cnt_reg;
        value_next    = '0;
        status_next   = ST_OK;
        do_push_front = 1'b0;
        do_push_rear  = 1'b0;
        do_pop_front  = 1'b0;
        case (action)
            ACT_PUSH_FRONT, ACT_PUSH_REAR:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    cnt_next      = cnt_reg + CNT_W'(1);
                    do_push_front = (action == ACT_PUSH_FRONT);
                    do_push_rear  = (action == ACT_PUSH_REAR);
                end
            end
            ACT_POP_FRONT, ACT_POP_REAR, ACT_PEEK_FRONT, ACT_PEEK_REAR:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    if (action == ACT_POP_FRONT || action == ACT_PEEK_FRONT)
                    begin
                        value_next = cell_data[0];
                    end
                    else
                    begin
                        value_next = rear_data;
                    end
                    if (action == ACT_POP_FRONT || action == ACT_POP_REAR)
                    begin
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                    do_pop_front = (action == ACT_POP_FRONT);
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < NCELL; g++)
        begin : g_cell
            logic [DATA_W-1:0] left_in;
            logic [DATA_W-1:0] right_in;

            if (g == 0)
            begin : g_first
                assign left_in = item;
            end
            else
            begin : g_mid_l
                assign left_in = cell_data[g-1];
            end

            if (g == NCELL - 1)
            begin : g_last
                assign right_in = cell_data[g];
            end
            else
            begin : g_mid_r
                assign right_in = cell_data[g+1];
            end

            assign cell_ctrl[g].load       = accept && do_push_rear &&
                                             (cnt_reg == CNT_W'(g));
            assign cell_ctrl[g].take_left  = accept && do_push_front;
            assign cell_ctrl[g].take_right = accept && do_pop_front;

            cdq_cell u_cell (
                .clk      (clk),
                .ctrl     (cell_ctrl[g]),
                .left_in  (left_in),
                .right_in (right_in),
                .item     (item),
                .data     (cell_data[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg  <= value_next;
            status_reg <= status_next;
            fill_reg   <= FILL_W'(cnt_next);
        end
    end

    assign done   = done_reg;
    assign value  = value_reg;
    assign status = status_reg;
    assign fill   = fill_reg;

    `CDQ_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(NCELL), "count past capacity")
    `CDQ_ASSERT_NXT(a_done_follows, clk, rst_n, accept, done, "missing result strobe")
    `CDQ_ASSERT_IMP(a_fill_cnt, clk, rst_n, done, fill == FILL_W'(cnt_reg), "fill out of step")
    `CDQ_ASSERT_IMP(a_err_zero, clk, rst_n, done && status != ST_OK, value == '0, "error value not zero")
    `CDQ_ASSERT_IMP(a_full_fill, clk, rst_n, done && status == ST_FULL, cnt_reg == CNT_W'(NCELL), "full refusal below capacity")

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import cdq_pkg::*;

    localparam logic [ACT_W-1:0] ACT_NOP_A = 3'd6;
    localparam logic [ACT_W-1:0] ACT_NOP_B = 3'd7;
    localparam int RANDOM_CMDS = 1200;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_LIMIT = 1000;

    typedef struct {
        logic [DATA_W-1:0] value;
        logic [STAT_W-1:0] status;
        logic [FILL_W-1:0] fill;
    } deque_result_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [ACT_W-1:0]  action;
    logic [DATA_W-1:0] item;
    logic              done;
    logic [DATA_W-1:0] value;
    logic [STAT_W-1:0] status;
    logic [FILL_W-1:0] fill;

    logic [DATA_W-1:0] ring_mem [DEPTH];
    logic [CNT_W-1:0]  front_mark;
    logic [CNT_W-1:0]  rear_mark;
    deque_result_t     pending_results [$];

    int errors;
    int beats_sent;
    int results_seen;
    int full_refusals;
    int empty_refusals;
    int nop_cmds;
    int idle_cycles;
    int burst_left;
    bit gaps_on;

    circular_byte_deque uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .action (action),
        .item   (item),
        .done   (done),
        .value  (value),
        .status (status),
        .fill   (fill)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic deque_result_t apply_action(input logic [ACT_W-1:0] act,
                                                   input logic [DATA_W-1:0] din);
        deque_result_t    res;
        logic             no_items;
        logic             is_full;
        logic [CNT_W-1:0] rear_next;
        logic [CNT_W-1:0] front_next;
        logic [CNT_W-1:0] held;
        res.value  = '0;
        res.status = ST_OK;
        rear_next  = rear_mark + 1'b1;
        front_next = front_mark + 1'b1;
        no_items   = (front_mark == rear_mark);
        is_full    = (rear_next == front_mark);
        case (act)
            ACT_PUSH_FRONT:
                if (is_full) res.status = ST_FULL;
                else
                begin
                    ring_mem[front_mark] = din;
                    front_mark = front_mark - 1'b1;
                end
            ACT_PUSH_REAR:
                if (is_full) res.status = ST_FULL;
                else
                begin
                    rear_mark = rear_next;
                    ring_mem[rear_mark] = din;
                end
            ACT_POP_FRONT:
                if (no_items) res.status = ST_EMPTY;
                else
                begin
                    front_mark = front_next;
                    res.value = ring_mem[front_mark];
                end
            ACT_POP_REAR:
                if (no_items) res.status = ST_EMPTY;
                else
                begin
                    res.value = ring_mem[rear_mark];
                    rear_mark = rear_mark - 1'b1;
                end
            ACT_PEEK_FRONT:
                if (no_items) res.status = ST_EMPTY;
                else res.value = ring_mem[front_next];
            ACT_PEEK_REAR:
                if (no_items) res.status = ST_EMPTY;
                else res.value = ring_mem[rear_mark];
            default:
                nop_cmds++;
        endcase
        if (res.status == ST_FULL) full_refusals++;
        if (res.status == ST_EMPTY) empty_refusals++;
        held = rear_mark - front_mark;
        res.fill = FILL_W'(held);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        errors++;
    endtask

    // predict on every accepted beat, then check the result strobe
    always @(posedge clk)
    begin
        deque_result_t want;
        if (rst_n)
        begin
            if (start && !busy)
                pending_results.push_back(apply_action(action, item));
            if (done)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                    report_mismatch("result with nothing pending, value", value, 0);
                else
                begin
                    want = pending_results.pop_front();
                    if (value !== want.value) report_mismatch("value", value, want.value);
                    if (status !== want.status) report_mismatch("status", status, want.status);
                    if (fill !== want.fill) report_mismatch("fill", fill, want.fill);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_beat(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] din);
        int gap;
        if (gaps_on && burst_left == 0)
        begin
            gap = $urandom_range(1, 10);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0) burst_left--;
        start  <= 1'b1;
        action <= act;
        item   <= din;
        @(posedge clk);
        while (busy) @(posedge clk);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic test_empty_refusals;
        gaps_on = 1'b1;
        send_beat(ACT_POP_FRONT, 8'($urandom));
        send_beat(ACT_POP_REAR, 8'($urandom));
        send_beat(ACT_PEEK_FRONT, 8'($urandom));
        send_beat(ACT_PEEK_REAR, 8'($urandom));
        send_beat(ACT_NOP_A, 8'($urandom));
    endtask

    task automatic test_fill_to_full;
        logic [DATA_W-1:0] din;
        gaps_on = 1'b0;
        for (int i = 0; i < DEPTH - 1; i++)
        begin
            din = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom);
            send_beat((i % 2) ? ACT_PUSH_REAR : ACT_PUSH_FRONT, din);
        end
        send_beat(ACT_PUSH_FRONT, 8'hA5);
        send_beat(ACT_PUSH_REAR, 8'h5A);
        send_beat(ACT_NOP_B, 8'hFF);
        send_beat(ACT_POP_FRONT, 8'h00);
        send_beat(ACT_POP_REAR, 8'h00);
    endtask

    task automatic test_random_mix;
        int sent;
        int run_len;
        int push_pct;
        int pick;
        logic [ACT_W-1:0]  act;
        logic [DATA_W-1:0] din;
        sent = 0;
        while (sent < RANDOM_CMDS)
        begin
            // switch at random between filling, draining and balanced stretches
            gaps_on  = ($urandom_range(0, 3) != 0);
            pick     = $urandom_range(0, 2);
            push_pct = (pick == 0) ? 15 : ((pick == 1) ? 50 : 85);
            run_len  = $urandom_range(20, 60);
            for (int k = 0; k < run_len; k++)
            begin
                if ($urandom_range(0, 99) < 3)
                    act = $urandom_range(0, 1) ? ACT_NOP_B : ACT_NOP_A;
                else if ($urandom_range(0, 99) < push_pct)
                    act = $urandom_range(0, 1) ? ACT_PUSH_REAR : ACT_PUSH_FRONT;
                else
                    act = ACT_W'($urandom_range(ACT_POP_FRONT, ACT_PEEK_REAR));
                pick = $urandom_range(0, 9);
                din = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
                send_beat(act, din);
                sent++;
            end
        end
    endtask

    initial
    begin
        int guard;
        rst_n      = 1'b0;
        start      = 1'b0;
        action     = ACT_PUSH_FRONT;
        item       = '0;
        front_mark = '0;
        rear_mark  = '0;
        errors     = 0;
        beats_sent = 0;
        results_seen   = 0;
        full_refusals  = 0;
        empty_refusals = 0;
        nop_cmds    = 0;
        idle_cycles = 0;
        burst_left  = 0;
        gaps_on     = 1'b0;
        for (int i = 0; i < DEPTH; i++) ring_mem[i] = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        test_empty_refusals();
        test_fill_to_full();
        test_random_mix();

        start <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0d results never arrived", pending_results.size());
            errors++;
        end

        $display("sent %0d commands and checked %0d results, %0d mismatches",
                 beats_sent, results_seen, errors);
        $display("refusals seen: %0d full, %0d empty; %0d unused action codes",
                 full_refusals, empty_refusals, nop_cmds);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/cdq_pkg.sv
src/cdq_cell.sv
src/circular_byte_deque.sv
verif/testbench.sv
